@@ hdl/simhyd_rainfall_runoff_step_defines.svh @@
// ----------------------------------------------------------------------------
// SIMHYD step assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIMHYD_RAINFALL_RUNOFF_STEP_DEFINES_SVH
`define SIMHYD_RAINFALL_RUNOFF_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIMHYD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIMHYD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/simhyd_pkg.sv @@
// ----------------------------------------------------------------------------
// SIMHYD package
// Register indexes, widths, fraction clamp and the exp table generator.
// ----------------------------------------------------------------------------
package simhyd_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 17;
	localparam int SHAPE_W = 20;
	localparam int RATIO_W = 17;
	localparam int CFG_INDEX_W = 3;
	localparam int EXP_TABLE_BITS_DEFAULT = 8;
	localparam int SOIL_ET_SCALE = 10;
	localparam logic [32:0] LOG2E_Q16 = 33'd94548;
	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [CFG_INDEX_W-1:0] REG_INTERCEPTION_CAPACITY = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INFILTRATION_COEFFICIENT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INFILTRATION_SHAPE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SOIL_CAPACITY = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERFLOW_FRACTION = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RECHARGE_FRACTION = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BASEFLOW_RATE = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SOIL_FRACTION = 3'd7;

	function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
		return (f > ONE_Q16) ? ONE_Q16 : f;
	endfunction

	// Largest Q0.32 root whose repeated truncated square stays at or below one half.
	function automatic logic [63:0] exp_root(input int bits);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] c;
		lo = 64'd0;
		hi = 64'h1_0000_0000;
		while (hi - lo > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			c = mid;
			for (int k = 0; k < bits; k++) begin
				c = (c * c) >> 32;
			end
			if (c <= 64'h8000_0000) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic logic [32:0] exp_entry(input int bits, input int i);
		logic [63:0] c;
		logic [63:0] t;
		c = exp_root(bits);
		t = 64'h1_0000_0000;
		for (int k = 1; k <= i; k++) begin
			t = (t * c + 64'h8000_0000) >> 32;
		end
		return t[32:0];
	endfunction

endpackage

@@ hdl/simhyd_ratio_div.sv @@
// ----------------------------------------------------------------------------
// SIMHYD soil ratio divider
// Restoring divider giving min(soil, capacity) * 65536 / capacity, one bit a cycle.
// ----------------------------------------------------------------------------
module simhyd_ratio_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [simhyd_pkg::DATA_W-1:0]       dividend,
	input  logic [simhyd_pkg::DATA_W-1:0]       divisor,
	output logic                                done,
	output logic [simhyd_pkg::RATIO_W-1:0]      quotient
);
	import simhyd_pkg::*;

	localparam int CNT_W = $clog2(RATIO_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RATIO_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W:0]     rem_q;
	logic [RATIO_W-1:0]  quot_q;
	logic [DATA_W+1:0]   trial;
	logic                fits;

	always_comb begin
		trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		fits = trial >= {2'b00, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (DATA_W+1)'(trial - {2'b00, divisor}) : trial[DATA_W:0];
			quot_q <= {quot_q[RATIO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quot_q;

endmodule

@@ hdl/simhyd_rainfall_runoff_step.sv @@
// Each accepted input beat yields a result beat, delayed further only while a
// previous result is still stalled in the output register.
// Input stalls until the result is registered; the 17-step ratio divider and the
// single shared multiplier, used once in each of eleven sequencer steps, set the pace.
// Reset clears configuration to defaults and both stores to zero.
// ----------------------------------------------------------------------------
// SIMHYD rainfall-runoff step
// Soil and groundwater water balance for one timestep in unsigned Q16.16.
// ----------------------------------------------------------------------------
`include "simhyd_rainfall_runoff_step_defines.svh"

module simhyd_rainfall_runoff_step #(
	parameter int EXP_TABLE_BITS = simhyd_pkg::EXP_TABLE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [simhyd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [simhyd_pkg::DATA_W-1:0]        cfg_data,
	input  logic                                 step_valid,
	output logic                                 step_stall,
	input  logic [simhyd_pkg::DATA_W-1:0]        rain,
	input  logic [simhyd_pkg::DATA_W-1:0]        pet,
	input  logic                                 restart,
	input  logic [simhyd_pkg::DATA_W-1:0]        initial_groundwater,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [simhyd_pkg::DATA_W-1:0]        runoff,
	output logic [simhyd_pkg::DATA_W-1:0]        actual_et
);
	import simhyd_pkg::*;

	localparam int TBL_N = 1 << EXP_TABLE_BITS;
	localparam int SH = 16 - EXP_TABLE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_DIV_START, ST_DIV_WAIT, ST_SHAPE, ST_LOG2E, ST_LOOKUP,
		ST_INTERP, ST_EXPV, ST_INFCAP, ST_SPLIT, ST_SRUN, ST_REC, ST_REC_MUL, ST_ET,
		ST_BASE, ST_SUM, ST_DRY, ST_OVER, ST_FIN
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0]  icap_q, coef_q, scap_q;
	logic [SHAPE_W-1:0] shape_q;
	logic [FRAC_W-1:0]  ifrac_q, rfrac_q, bfrac_q, isf_q;

	logic [DATA_W-1:0]  rain_q, pet_q, igw_q, cap_q;
	logic               restart_q;
	logic [DATA_W-1:0]  soil_q, gw_q;
	logic [DATA_W-1:0]  intc_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [4:0]         n_q;
	logic [SH-1:0]      part_q;
	logic [32:0]        t0_q;
	logic [32:0]        diff_q;
	logic [RATIO_W-1:0] e_q;
	logic [DATA_W-1:0]  rmo_q, irun_q, srun_q, rs_q, smf_q, bas_q;
	logic [33:0]        rec_q;
	logic [20:0]        et_q;
	logic [DATA_W:0]    sum_q, sms_q;
	logic [65:0]        prod_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  runoff_q, et_out_q;

	logic [32:0]        mul_a, mul_b;
	logic [65:0]        mul_p;
	logic [32:0]        exp_tbl [TBL_N+1];
	logic [EXP_TABLE_BITS-1:0] tbl_idx;
	logic [EXP_TABLE_BITS:0]   tbl_lo, tbl_hi;
	logic [DATA_W-1:0]  s_cur, div_m, imax, intc_new;
	logic [32:0]        v_exp, v_shift;
	logic [33:0]        v_round;
	logic [32:0]        infcap;
	logic [DATA_W-1:0]  inr, pot, rmo_new, srun_new, rec_new;
	logic [20:0]        et_raw;
	logic [34:0]        gw_sum;
	logic [33:0]        run_sum;
	logic               div_start, div_done;
	logic [RATIO_W-1:0] div_quot;
	logic               step_take, out_free;

	for (genvar g = 0; g <= TBL_N; g++) begin : g_exp_tbl
		assign exp_tbl[g] = exp_entry(EXP_TABLE_BITS, g);
	end

	assign cfg_ready = 1'b1;
	assign step_stall = (state_q != ST_IDLE);
	assign step_take = step_valid && !step_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign runoff = runoff_q;
	assign actual_et = et_out_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LOAD: begin
				mul_a = 33'(clamp_frac(isf_q));
				mul_b = {1'b0, cap_q};
			end
			ST_SHAPE: begin
				mul_a = 33'(shape_q);
				mul_b = 33'(ratio_q);
			end
			ST_LOG2E: begin
				mul_a = 33'(prod_q[35:16]);
				mul_b = LOG2E_Q16;
			end
			ST_INTERP: begin
				mul_a = diff_q;
				mul_b = 33'(part_q);
			end
			ST_INFCAP: begin
				mul_a = {1'b0, coef_q};
				mul_b = 33'(e_q);
			end
			ST_SPLIT: begin
				mul_a = 33'(clamp_frac(ifrac_q));
				mul_b = 33'(ratio_q);
			end
			ST_SRUN: begin
				mul_a = 33'(prod_q[32:16]);
				mul_b = {1'b0, rmo_q};
			end
			ST_REC: begin
				mul_a = 33'(clamp_frac(rfrac_q));
				mul_b = 33'(ratio_q);
			end
			ST_REC_MUL: begin
				mul_a = 33'(prod_q[32:16]);
				mul_b = {1'b0, rs_q};
			end
			ST_ET: begin
				mul_a = 33'(SOIL_ET_SCALE);
				mul_b = 33'(ratio_q);
			end
			ST_BASE: begin
				mul_a = 33'(clamp_frac(bfrac_q));
				mul_b = {1'b0, gw_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		s_cur = restart_q ? prod_q[47:16] : soil_q;
		div_m = (s_cur < cap_q) ? s_cur : cap_q;
		imax = (icap_q < pet_q) ? icap_q : pet_q;
		intc_new = (imax < rain_q) ? imax : rain_q;
		tbl_idx = prod_q[31:16+SH];
		tbl_lo = {1'b0, tbl_idx};
		tbl_hi = tbl_lo + 1'b1;
		v_exp = t0_q - {1'b0, prod_q[SH+31:SH]};
		v_shift = v_exp >> n_q;
		v_round = {1'b0, v_shift} + 34'h8000;
		infcap = prod_q[48:16];
		inr = rain_q - intc_q;
		rmo_new = (infcap < {1'b0, inr}) ? infcap[31:0] : inr;
		srun_new = prod_q[47:16];
		rec_new = prod_q[47:16];
		pot = pet_q - intc_q;
		et_raw = prod_q[20:0];
		gw_sum = {3'b000, gw_q} + {1'b0, rec_q} - {3'b000, bas_q};
		run_sum = {2'b00, irun_q} + {2'b00, srun_q} + {2'b00, bas_q};
	end

	assign div_start = (state_q == ST_DIV_START);

	simhyd_ratio_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_m),
		.divisor  (cap_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icap_q <= 32'd65536;
			coef_q <= 32'd13107200;
			shape_q <= 20'd196608;
			scap_q <= 32'd19660800;
			ifrac_q <= 17'd32768;
			rfrac_q <= 17'd6554;
			bfrac_q <= 17'd6554;
			isf_q <= 17'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INTERCEPTION_CAPACITY: icap_q <= cfg_data;
				REG_INFILTRATION_COEFFICIENT: coef_q <= cfg_data;
				REG_INFILTRATION_SHAPE: shape_q <= cfg_data[SHAPE_W-1:0];
				REG_SOIL_CAPACITY: scap_q <= cfg_data;
				REG_INTERFLOW_FRACTION: ifrac_q <= cfg_data[FRAC_W-1:0];
				REG_RECHARGE_FRACTION: rfrac_q <= cfg_data[FRAC_W-1:0];
				REG_BASEFLOW_RATE: bfrac_q <= cfg_data[FRAC_W-1:0];
				REG_INITIAL_SOIL_FRACTION: isf_q <= cfg_data[FRAC_W-1:0];
				default: icap_q <= icap_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			soil_q <= '0;
			gw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (step_take) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_DIV_START;
				ST_DIV_START: begin
					if (restart_q) begin
						soil_q <= prod_q[47:16];
						gw_q <= igw_q;
					end
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_SHAPE;
					end
				end
				ST_SHAPE: state_q <= ST_LOG2E;
				ST_LOG2E: state_q <= ST_LOOKUP;
				ST_LOOKUP: state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_EXPV;
				ST_EXPV: state_q <= ST_INFCAP;
				ST_INFCAP: state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= ST_SRUN;
				ST_SRUN: state_q <= ST_REC;
				ST_REC: state_q <= ST_REC_MUL;
				ST_REC_MUL: state_q <= ST_ET;
				ST_ET: state_q <= ST_BASE;
				ST_BASE: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DRY;
				ST_DRY: state_q <= ST_OVER;
				ST_OVER: begin
					if (sms_q > {1'b0, cap_q}) begin
						soil_q <= cap_q;
					end else begin
						soil_q <= sms_q[31:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						gw_q <= (gw_sum > 35'hFFFF_FFFF) ? 32'hFFFF_FFFF : gw_sum[31:0];
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (step_take) begin
			rain_q <= rain;
			pet_q <= pet;
			restart_q <= restart;
			igw_q <= initial_groundwater;
			cap_q <= (scap_q == '0) ? 32'd1 : scap_q;
		end
		if (state_q == ST_DIV_START) begin
			intc_q <= intc_new;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			ratio_q <= div_quot;
		end
		if (state_q == ST_LOOKUP) begin
			n_q <= prod_q[36:32];
			part_q <= prod_q[SH+15:16];
			t0_q <= exp_tbl[tbl_lo];
			diff_q <= exp_tbl[tbl_lo] - exp_tbl[tbl_hi];
		end
		if (state_q == ST_EXPV) begin
			e_q <= v_round[32:16];
		end
		if (state_q == ST_SPLIT) begin
			rmo_q <= rmo_new;
			irun_q <= inr - rmo_new;
		end
		if (state_q == ST_REC) begin
			srun_q <= srun_new;
			rs_q <= rmo_q - srun_new;
		end
		if (state_q == ST_ET) begin
			rec_q <= {2'b00, rec_new};
			smf_q <= rs_q - rec_new;
		end
		if (state_q == ST_BASE) begin
			et_q <= ({11'b0, et_raw} > pot) ? pot[20:0] : et_raw;
		end
		if (state_q == ST_SUM) begin
			bas_q <= prod_q[47:16];
			sum_q <= {1'b0, soil_q} + {1'b0, smf_q};
		end
		if (state_q == ST_DRY) begin
			sms_q <= (sum_q > {12'b0, et_q}) ? sum_q - {12'b0, et_q} : '0;
		end
		if (state_q == ST_OVER && sms_q > {1'b0, cap_q}) begin
			rec_q <= rec_q + {1'b0, sms_q - {1'b0, cap_q}};
		end
		if (state_q == ST_FIN && out_free) begin
			runoff_q <= (run_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_sum[31:0];
			et_out_q <= {11'b0, et_q};
		end
	end

	`SIMHYD_ASSERT_NEXT(a_busy_after_accept, step_take, step_stall, "Accepted step did not stall input.")
	`SIMHYD_ASSERT_NOW(a_ratio_range, state_q == ST_SHAPE, ratio_q <= ONE_Q16, "Soil ratio above one.")
	`SIMHYD_ASSERT_NOW(a_result_from_fin, $rose(result_valid), $past(state_q) == ST_FIN, "Result beat not from final step.")
	`SIMHYD_ASSERT_NOW(a_div_done_expected, div_done, state_q == ST_DIV_WAIT, "Divider finished outside its wait.")

endmodule
